// ----- rtl/rwat_pkg.sv -----
// Shared types, codes and defaults for the Reno window and acknowledgement tracker.
package rwat_pkg;

    // Fixed field widths of the streams and the configuration port
    localparam int ACT_W  = 2;
    localparam int SEQ_W  = 32;
    localparam int CNT_W  = 11;
    localparam int EV_W   = 3;
    localparam int TMO_W  = 24;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 24;

    // Packed stream widths; the data widths are padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = ACT_W;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = EV_W;

    // Parameter defaults
    localparam int WINDOW_BOUND_DEF = 1024;
    localparam int TIMER_BITS_DEF   = 24;

    // Configuration reset values
    localparam logic [CNT_W-1:0] INIT_TH_RST  = 11'd16;
    localparam logic [CNT_W-1:0] MAX_WIN_RST  = 11'd64;
    localparam logic [TMO_W-1:0] TIMEOUT_RST  = 24'd500;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_INIT_TH = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_WIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // Input actions
    localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd3;

    // Result events
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_ACK     = 3'd1;
    localparam logic [EV_W-1:0] EV_DUP     = 3'd2;
    localparam logic [EV_W-1:0] EV_DONE    = 3'd3;
    localparam logic [EV_W-1:0] EV_FAST    = 3'd4;
    localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd5;
    localparam logic [EV_W-1:0] EV_ORDER   = 3'd6;

    // Duplicate acknowledgements that trigger a fast retransmit
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] initial_threshold;
        logic [CNT_W-1:0] max_window;
        logic [TMO_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] ack_number;
        logic [CNT_W-1:0] window_packets;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [CNT_W-1:0] congestion_window;
        logic [CNT_W-1:0] slow_start_threshold;
        logic [SEQ_W-1:0] next_sequence;
        logic [CNT_W-1:0] acked_count;
    } result_t;

endpackage

// ----- rtl/rwat_cfg.sv -----
// Configuration registers of the tracker, written through a plain write port.
module rwat_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rwat_pkg::IDX_W-1:0] cfg_index,
    input  logic [rwat_pkg::CFG_W-1:0] cfg_wdata,
    output rwat_pkg::cfg_t             cfg
);
    import rwat_pkg::*;

    cfg_t cfg_reg;

    // Decode the index and load the addressed register; unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_threshold <= INIT_TH_RST;
            cfg_reg.max_window        <= MAX_WIN_RST;
            cfg_reg.timeout_ticks     <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INIT_TH: cfg_reg.initial_threshold <= cfg_wdata[CNT_W-1:0];
                REG_MAX_WIN: cfg_reg.max_window        <= cfg_wdata[CNT_W-1:0];
                REG_TIMEOUT: cfg_reg.timeout_ticks     <= cfg_wdata[TMO_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/rwat_core.sv -----
// Window, threshold, acknowledgement and timer state with its single-pass update.
module rwat_core #(
    parameter int WINDOW_BOUND = rwat_pkg::WINDOW_BOUND_DEF,
    parameter int TIMER_BITS   = rwat_pkg::TIMER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rwat_pkg::cfg_t    cfg,
    input  logic              fire,
    input  rwat_pkg::item_t   item,
    output rwat_pkg::result_t result
);
    import rwat_pkg::*;

    localparam int WIN_W = $clog2(WINDOW_BOUND + 1);
    localparam int TH_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam logic [WIN_W-1:0]      BOUND_W   = WIN_W'(WINDOW_BOUND);
    localparam logic [WIN_W-1:0]      ONE_W     = WIN_W'(1);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [WIN_W-1:0]      window_size_reg, window_size_next;
    logic [TH_W-1:0]       threshold_reg, threshold_next;
    logic [SEQ_W-1:0]      base_sequence_reg, base_sequence_next;
    logic [SEQ_W-1:0]      last_ack_reg, last_ack_next;
    logic [WIN_W-1:0]      open_length_reg, open_length_next;
    logic [WIN_W-1:0]      acks_seen_reg, acks_seen_next;
    logic [1:0]            duplicate_count_reg, duplicate_count_next;
    logic [TIMER_BITS-1:0] wait_timer_reg, wait_timer_next;
    logic                  waiting_reg, waiting_next;
    logic [EV_W-1:0]       event_code;

    // Next state and event for the item at the head of the input register
    always_comb
    begin
        logic [SEQ_W-1:0]      diff;
        logic                  in_window;
        logic [WIN_W-1:0]      ws_grown;
        logic [WIN_W-1:0]      acks_inc;
        logic [1:0]            dup_inc;
        logic [TIMER_BITS-1:0] timer_inc;

        window_size_next     = window_size_reg;
        threshold_next       = threshold_reg;
        base_sequence_next   = base_sequence_reg;
        last_ack_next        = last_ack_reg;
        open_length_next     = open_length_reg;
        acks_seen_next       = acks_seen_reg;
        duplicate_count_next = duplicate_count_reg;
        wait_timer_next      = wait_timer_reg;
        waiting_next         = waiting_reg;
        event_code           = EV_NONE;

        diff      = item.ack_number - base_sequence_reg;
        in_window = (item.ack_number >= base_sequence_reg)
                    && (diff < SEQ_W'(open_length_reg));
        acks_inc  = (acks_seen_reg < BOUND_W) ? acks_seen_reg + ONE_W : acks_seen_reg;
        dup_inc   = (duplicate_count_reg < DUP_LIMIT) ? duplicate_count_reg + 2'd1
                                                      : duplicate_count_reg;
        timer_inc = (wait_timer_reg < TIMER_MAX) ? wait_timer_reg + TIMER_BITS'(1)
                                                 : wait_timer_reg;

        // Slow-start growth on an in-window acknowledgement
        ws_grown = window_size_reg;
        if ((TH_W'(window_size_reg) < threshold_reg) && (window_size_reg < BOUND_W))
        begin
            ws_grown = window_size_reg + ONE_W;
        end

        unique case (item.action)
            ACT_BEGIN:
            begin
                window_size_next     = ONE_W;
                threshold_next       = TH_W'(cfg.initial_threshold);
                base_sequence_next   = SEQ_W'(1);
                last_ack_next        = '0;
                open_length_next     = '0;
                acks_seen_next       = '0;
                duplicate_count_next = '0;
                wait_timer_next      = '0;
                waiting_next         = 1'b0;
            end
            ACT_OPEN:
            begin
                open_length_next = (item.window_packets > WINDOW_BOUND)
                                   ? BOUND_W : WIN_W'(item.window_packets);
                acks_seen_next   = '0;
                wait_timer_next  = '0;
                waiting_next     = (item.window_packets != '0);
            end
            ACT_ACK:
            begin
                if (waiting_reg)
                begin
                    if (in_window)
                    begin
                        last_ack_next      = item.ack_number;
                        base_sequence_next = item.ack_number + SEQ_W'(1);
                        acks_seen_next     = acks_inc;
                        window_size_next   = ws_grown;
                        if (acks_inc >= open_length_reg)
                        begin
                            // Congestion-avoidance growth once the window completes
                            if ((TH_W'(ws_grown) >= threshold_reg)
                                && (TH_W'(ws_grown) < TH_W'(cfg.max_window))
                                && (ws_grown < BOUND_W))
                            begin
                                window_size_next = ws_grown + ONE_W;
                            end
                            waiting_next = 1'b0;
                            event_code   = EV_DONE;
                        end
                        else
                        begin
                            event_code = EV_ACK;
                        end
                    end
                    else if (item.ack_number == last_ack_reg)
                    begin
                        if (dup_inc >= DUP_LIMIT)
                        begin
                            threshold_next       = TH_W'(window_size_reg >> 1);
                            window_size_next     = ONE_W;
                            duplicate_count_next = '0;
                            wait_timer_next      = '0;
                            event_code           = EV_FAST;
                        end
                        else
                        begin
                            duplicate_count_next = dup_inc;
                            event_code           = EV_DUP;
                        end
                    end
                    else
                    begin
                        event_code = EV_ORDER;
                    end
                end
            end
            ACT_TICK:
            begin
                if (waiting_reg)
                begin
                    if (timer_inc > cfg.timeout_ticks)
                    begin
                        threshold_next       = TH_W'(window_size_reg >> 1);
                        window_size_next     = ONE_W;
                        duplicate_count_next = '0;
                        wait_timer_next      = '0;
                        event_code           = EV_TIMEOUT;
                    end
                    else
                    begin
                        wait_timer_next = timer_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg     <= ONE_W;
            threshold_reg       <= TH_W'(INIT_TH_RST);
            base_sequence_reg   <= SEQ_W'(1);
            last_ack_reg        <= '0;
            open_length_reg     <= '0;
            acks_seen_reg       <= '0;
            duplicate_count_reg <= '0;
            wait_timer_reg      <= '0;
            waiting_reg         <= 1'b0;
        end
        else if (fire)
        begin
            window_size_reg     <= window_size_next;
            threshold_reg       <= threshold_next;
            base_sequence_reg   <= base_sequence_next;
            last_ack_reg        <= last_ack_next;
            open_length_reg     <= open_length_next;
            acks_seen_reg       <= acks_seen_next;
            duplicate_count_reg <= duplicate_count_next;
            wait_timer_reg      <= wait_timer_next;
            waiting_reg         <= waiting_next;
        end
    end

    // Result reports the state after this item
    assign result.event_res            = event_code;
    assign result.congestion_window    = CNT_W'(window_size_next);
    assign result.slow_start_threshold = CNT_W'(threshold_next);
    assign result.next_sequence        = base_sequence_next;
    assign result.acked_count          = CNT_W'(acks_seen_next);

`ifndef SYNTHESIS
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_size_reg != '0) && (window_size_reg <= BOUND_W))
        else $error("congestion window left its range");

    a_dup_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        duplicate_count_reg < DUP_LIMIT)
        else $error("duplicate count reached the limit without a retransmit");

    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.action == ACT_BEGIN)
        |=> (window_size_reg == ONE_W) && !waiting_reg && (acks_seen_reg == '0))
        else $error("begin file did not restore the start state");
`endif

endmodule

// ----- rtl/reno_window_ack_tracker.sv -----
// Top level of the Reno window and acknowledgement tracker: stream stages around the core.
//
// Channel   | Direction | Payload
// s_*       | in        | tuser: action; tdata: ack_number, window_packets
// m_*       | out       | tuser: event_res; tdata: window, threshold, base, acked count
// cfg_*     | in        | write enable, register index, write data
//
// One item per cycle sustained while the output is not stalled; an item passes through
// the input register and then the result register around the core update.
// Reset restores the configuration defaults and the start state of a file transfer.
// A stalled output holds its result while the input register still takes one more item.
module reno_window_ack_tracker #(
    parameter int WINDOW_BOUND = rwat_pkg::WINDOW_BOUND_DEF,
    parameter int TIMER_BITS   = rwat_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rwat_pkg::S_DATA_W-1:0] s_tdata,  // ack_number, window_packets, zeros
    input  logic [rwat_pkg::S_USER_W-1:0] s_tuser,  // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // congestion_window, slow_start_threshold, next_sequence, acked_count, zeros
    output logic [rwat_pkg::M_DATA_W-1:0] m_tdata,
    output logic [rwat_pkg::M_USER_W-1:0] m_tuser,  // event_res
    input  logic                          cfg_we,
    input  logic [rwat_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rwat_pkg::CFG_W-1:0]    cfg_wdata
);
    import rwat_pkg::*;

    localparam int RES_W = 4 * CNT_W + SEQ_W - CNT_W;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    fire;

    rwat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rwat_core #(
        .WINDOW_BOUND (WINDOW_BOUND),
        .TIMER_BITS   (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    // The held item is processed whenever the result register is free or drains
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.action         <= s_tuser;
            in_item_reg.ack_number     <= s_tdata[SEQ_W-1:0];
            in_item_reg.window_packets <= s_tdata[SEQ_W+CNT_W-1:SEQ_W];
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.event_res;
    assign m_tdata  = {{(M_DATA_W-RES_W){1'b0}},
                       out_result_reg.acked_count,
                       out_result_reg.next_sequence,
                       out_result_reg.slow_start_threshold,
                       out_result_reg.congestion_window};

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed item produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready)
        |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("waiting result changed before it was taken");
`endif

endmodule

// ----- tb/sv/reno_window_ack_tracker_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Reno window and acknowledgement tracker stream block.

module reno_window_ack_tracker_test;

    import rwat_pkg::*;

    localparam int WIN_BOUND = WINDOW_BOUND_DEF;
    localparam logic [TMO_W-1:0] TIMER_FULL = '1;
    // Index past the register list; the block must ignore writes to it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // Predicts the tracker state per accepted item and holds the expected results
    class reno_tracker_scoreboard;
        logic [CNT_W-1:0] init_th;
        logic [CNT_W-1:0] max_win;
        logic [TMO_W-1:0] timeout;

        logic [CNT_W-1:0] cwnd;
        logic [CNT_W-1:0] ssthresh;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] last_ack;
        logic [CNT_W-1:0] open_len;
        logic [CNT_W-1:0] acks;
        logic [1:0]       dups;
        logic [TMO_W-1:0] timer;
        bit               waiting;

        result_t pending_results[$];
        int errors;
        int useful;
        int results_seen;
        int ev_count[8];

        function new();
            init_th = INIT_TH_RST;
            max_win = MAX_WIN_RST;
            timeout = TIMEOUT_RST;
            errors = 0;
            useful = 0;
            results_seen = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
            start_transfer();
        endfunction

        function void start_transfer();
            cwnd = 1;
            ssthresh = init_th;
            base = 1;
            last_ack = 0;
            open_len = 0;
            acks = 0;
            dups = 0;
            timer = 0;
            waiting = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_INIT_TH: init_th = val[CNT_W-1:0];
                REG_MAX_WIN: max_win = val[CNT_W-1:0];
                REG_TIMEOUT: timeout = val[TMO_W-1:0];
                default: ;
            endcase
        endfunction

        function void grow();
            if (cwnd < WIN_BOUND)
                cwnd = cwnd + 1'b1;
        endfunction

        function void retransmit();
            ssthresh = cwnd >> 1;
            cwnd = 1;
            dups = 0;
            timer = 0;
        endfunction

        // Classify one acknowledgement against the open window
        function logic [EV_W-1:0] absorb_ack(logic [SEQ_W-1:0] ack);
            logic [SEQ_W:0] offset;
            if (ack >= base)
            begin
                offset = {1'b0, ack} - {1'b0, base};
                if (offset < open_len)
                begin
                    last_ack = ack;
                    base = ack + 1'b1;
                    if (acks < WIN_BOUND)
                        acks = acks + 1'b1;
                    if (cwnd < ssthresh)
                        grow();
                    if (acks >= open_len)
                    begin
                        if (cwnd >= ssthresh && cwnd < max_win)
                            grow();
                        waiting = 0;
                        return EV_DONE;
                    end
                    return EV_ACK;
                end
            end
            if (ack == last_ack)
            begin
                if (dups < DUP_LIMIT)
                    dups = dups + 1'b1;
                if (dups >= DUP_LIMIT)
                begin
                    retransmit();
                    return EV_FAST;
                end
                return EV_DUP;
            end
            return EV_ORDER;
        endfunction

        function void record_item(item_t it);
            logic [CNT_W-1:0] n;
            result_t r;
            r.event_res = EV_NONE;
            if (it.action == ACT_BEGIN || it.action == ACT_OPEN || waiting)
                useful++;
            case (it.action)
                ACT_BEGIN: start_transfer();
                ACT_OPEN:
                begin
                    n = (it.window_packets > WIN_BOUND) ? CNT_W'(WIN_BOUND) : it.window_packets;
                    open_len = n;
                    acks = 0;
                    timer = 0;
                    waiting = (n != 0);
                end
                ACT_ACK:
                begin
                    if (waiting)
                        r.event_res = absorb_ack(it.ack_number);
                end
                default:
                begin
                    if (waiting)
                    begin
                        if (timer < TIMER_FULL)
                            timer = timer + 1'b1;
                        if (timer > timeout)
                        begin
                            retransmit();
                            r.event_res = EV_TIMEOUT;
                        end
                    end
                end
            endcase
            r.congestion_window = cwnd;
            r.slow_start_threshold = ssthresh;
            r.next_sequence = base;
            r.acked_count = acks;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual event %0d",
                         $time, got.event_res);
                return;
            end
            want = pending_results.pop_front();
            ev_count[got.event_res]++;
            compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
            compare_field("congestion_window", 32'(want.congestion_window),
                          32'(got.congestion_window));
            compare_field("slow_start_threshold", 32'(want.slow_start_threshold),
                          32'(got.slow_start_threshold));
            compare_field("next_sequence", want.next_sequence, got.next_sequence);
            compare_field("acked_count", 32'(want.acked_count), 32'(got.acked_count));
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // ack_number, window_packets, zeros
    logic [S_USER_W-1:0] s_tuser = '0;   // action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // cwnd, threshold, base, acked count, zeros
    logic [M_USER_W-1:0] m_tuser;        // event_res
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    reno_tracker_scoreboard sb = new();
    int src_idle_pct = 36;
    int dst_idle_pct = 54;
    int hold_left = 0;
    int settings_used = 1;

    reno_window_ack_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the whole run
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check each accepted item, then pick the ready for the next cycle
    always @(posedge clk)
    begin : result_side
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.event_res = m_tuser[EV_W-1:0];
            got.congestion_window = m_tdata[10:0];
            got.slow_start_threshold = m_tdata[21:11];
            got.next_sequence = m_tdata[53:22];
            got.acked_count = m_tdata[64:54];
            sb.check_result(got);
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Offer one item, with random idle cycles ahead of it, and wait for its acceptance
    task automatic send(logic [ACT_W-1:0] act, logic [SEQ_W-1:0] ack, logic [CNT_W-1:0] wp);
        item_t it;
        it.action = act;
        it.ack_number = ack;
        it.window_packets = wp;
        if (sb.useful < 470)
        begin
            src_idle_pct = 36;
            dst_idle_pct = 54;
        end
        else if (sb.useful < 940)
        begin
            src_idle_pct = 54;
            dst_idle_pct = 36;
        end
        else
        begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, wp, ack};
        s_tuser <= act;
        do @(posedge clk); while (!s_tready);
        sb.record_item(it);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers in a row, plus one write to an unused index
    task automatic program_regs(logic [CNT_W-1:0] th, logic [CNT_W-1:0] mw,
                                logic [TMO_W-1:0] tmo);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= REG_INIT_TH;
        cfg_wdata <= CFG_W'(th);
        @(posedge clk);
        sb.set_register(REG_INIT_TH, CFG_W'(th));
        cfg_index <= REG_MAX_WIN;
        cfg_wdata <= CFG_W'(mw);
        @(posedge clk);
        sb.set_register(REG_MAX_WIN, CFG_W'(mw));
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge clk);
        sb.set_register(REG_TIMEOUT, tmo);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= junk;
        @(posedge clk);
        sb.set_register(REG_UNUSED, junk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly well-formed transfers: begin, open a window, acknowledge it with some noise
    task automatic run_traffic(int target);
        int goal;
        int steps;
        int pick;
        logic [CNT_W-1:0] n;
        logic [SEQ_W-1:0] odd_ack;
        goal = sb.useful + target;
        while (sb.useful < goal)
        begin
            if ($urandom_range(99) < 70)
                send(ACT_BEGIN, $urandom, CNT_W'($urandom));
            pick = $urandom_range(99);
            if (pick < 80)
                n = CNT_W'($urandom_range(8, 1));
            else if (pick < 88)
                n = 0;
            else if (pick < 95)
                n = CNT_W'($urandom_range(1024, 9));
            else
                n = CNT_W'($urandom_range(2047, 1025));
            send(ACT_OPEN, $urandom, n);
            steps = 0;
            while (sb.waiting && steps < 14 && sb.useful < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 58)
                    send(ACT_ACK, sb.base, CNT_W'($urandom));
                else if (pick < 68)
                    send(ACT_ACK, sb.base + $urandom_range(sb.open_len - 1), CNT_W'($urandom));
                else if (pick < 78)
                    send(ACT_ACK, sb.last_ack, CNT_W'($urandom));
                else if (pick < 88)
                    send(ACT_TICK, $urandom, CNT_W'($urandom));
                else if (pick < 94)
                begin
                    case ($urandom_range(2))
                        0: odd_ack = '0;
                        1: odd_ack = '1;
                        default: odd_ack = $urandom;
                    endcase
                    send(ACT_ACK, odd_ack, CNT_W'($urandom));
                end
                else
                    send(ACT_W'($urandom_range(3)), $urandom, CNT_W'($urandom));
                steps++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings
        send(ACT_ACK, 32'hFFFF_FFFF, 11'd0);       // ack with no window open
        send(ACT_TICK, 32'd0, 11'h7FF);            // tick with no window open
        send(ACT_OPEN, 32'd7, 11'd0);              // empty window, nothing to wait for
        send(ACT_ACK, 32'd1, 11'd0);
        send(ACT_OPEN, 32'd0, 11'd2047);           // oversized window saturates
        send(ACT_OPEN, 32'hA5A5_5A5A, 11'd3);      // replaces the open window
        send(ACT_ACK, 32'd1, 11'd0);
        send(ACT_ACK, 32'd0, 11'd0);               // below the base, not a duplicate
        send(ACT_ACK, 32'hFFFF_FFFF, 11'd0);       // far past the window
        send(ACT_ACK, 32'd1, 11'd0);               // three duplicates: fast retransmit
        send(ACT_ACK, 32'd1, 11'd0);
        send(ACT_ACK, 32'd1, 11'd0);
        send(ACT_ACK, 32'd3, 11'd0);               // skips ahead inside the window
        send(ACT_ACK, 32'd4, 11'd0);               // completes the window
        send(ACT_TICK, 32'd0, 11'd0);
        send(ACT_BEGIN, 32'hFFFF_FFFF, 11'h7FF);
        send(ACT_OPEN, 32'd0, 11'd1);
        send(ACT_ACK, 32'd1, 11'd1);
        drain();

        // Low extremes: no slow start, no growth, timeout on the first tick
        program_regs(11'd0, 11'd1, 24'd0);
        send(ACT_BEGIN, 32'd0, 11'd0);
        send(ACT_OPEN, 32'd0, 11'd2);
        send(ACT_TICK, 32'd0, 11'd0);
        run_traffic(238);
        drain();

        // High extremes with a long receiver stall while items keep coming
        program_regs(11'd2047, 11'd1024, 24'hFF_FFFF);
        hold_left = 80;
        run_traffic(238);
        drain();

        program_regs(11'd1024, 11'd1024, 24'd3);
        run_traffic(238);
        drain();

        program_regs(CNT_W'($urandom_range(1024)), CNT_W'($urandom_range(1024, 1)),
                     TMO_W'($urandom_range(8, 1)));
        run_traffic(238);
        drain();

        program_regs(11'd4, 11'd8, 24'd2);
        hold_left = 60;
        run_traffic(238);
        drain();

        program_regs(INIT_TH_RST, MAX_WIN_RST, TIMEOUT_RST);
        run_traffic(200);
        drain();

        $display("Covered %0d counted items, %0d results, %0d register settings",
                 sb.useful, sb.results_seen, settings_used);
        $display("Events: ack %0d, dup %0d, done %0d, fast %0d, timeout %0d, order %0d",
                 sb.ev_count[EV_ACK], sb.ev_count[EV_DUP], sb.ev_count[EV_DONE],
                 sb.ev_count[EV_FAST], sb.ev_count[EV_TIMEOUT], sb.ev_count[EV_ORDER]);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
